@@ hw/rtl/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int MaxResults = 3;

  // Character codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U = 8'h75;

  // UTF-8 encoding constants
  localparam logic [15:0] UTF8_LIM1 = 16'h0080;
  localparam logic [15:0] UTF8_LIM2 = 16'h0800;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT = 8'h80;
  localparam logic [7:0] UTF8_MASK = 8'h3F;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX1   = 3'd2,
    MODE_HEX2   = 3'd3,
    MODE_HEX3   = 3'd4,
    MODE_HEX4   = 3'd5
  } mode_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } entry_t;

  // All results caused by one input byte
  typedef struct packed {
    logic [1:0]                  count;
    entry_t [MaxResults-1:0]     ent;
  } result_set_t;

  // Hex digit value; ok is low for anything outside 0-9, a-f, A-F
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      r = {1'b1, b[3:0] + 4'd9};
    return r;
  endfunction

  function automatic logic [7:0] escape_map(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    unique case (b)
      8'h6E:   r = 8'h0A; // n
      8'h72:   r = 8'h0D; // r
      8'h74:   r = 8'h09; // t
      8'h62:   r = 8'h08; // b
      8'h66:   r = 8'h0C; // f
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/jsu_decode.sv @@
// ----------------------------------------------------------------------------
// jsu_decode
// Escape state and per-byte decode: turns one body byte into 0..3 results.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output jsu_pkg::result_set_t res
);
  import jsu_pkg::*;

  mode_t       mode, mode_next;
  logic [15:0] hex_value, hex_value_next;
  logic        hex_stopped, hex_stopped_next;

  logic [4:0]  dig;
  logic [15:0] hv_upd;
  logic        hs_upd;
  logic        ended;

  always_comb begin
    dig = hex_digit(in_byte);
    hv_upd = hex_value;
    if (!hex_stopped && dig[4]) hv_upd = {hex_value[11:0], dig[3:0]};
    hs_upd = hex_stopped | ~dig[4];
  end

  always_comb begin
    mode_next = mode;
    hex_value_next = hex_value;
    hex_stopped_next = hex_stopped;
    res = '0;
    ended = 1'b0;
    unique case (mode)
      MODE_ESC: begin
        mode_next = MODE_NORMAL;
        if (in_byte == CH_U) begin
          mode_next = MODE_HEX1;
          hex_value_next = '0;
          hex_stopped_next = 1'b0;
        end else begin
          res.ent[0] = '{data: escape_map(in_byte), valid: 1'b1, last: 1'b0};
          res.count = 2'd1;
        end
      end
      MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        hex_value_next = hv_upd;
        hex_stopped_next = hs_upd;
        unique case (mode)
          MODE_HEX1: mode_next = MODE_HEX2;
          MODE_HEX2: mode_next = MODE_HEX3;
          default:   mode_next = MODE_HEX4;
        endcase
      end
      MODE_HEX4: begin
        // code point complete: encode as UTF-8
        if (hv_upd < UTF8_LIM1) begin
          res.ent[0] = '{data: hv_upd[7:0], valid: 1'b1, last: 1'b0};
          res.count = 2'd1;
        end else if (hv_upd < UTF8_LIM2) begin
          res.ent[0] = '{data: UTF8_LEAD2 | {3'b000, hv_upd[10:6]}, valid: 1'b1, last: 1'b0};
          res.ent[1] = '{data: UTF8_CONT | (hv_upd[7:0] & UTF8_MASK), valid: 1'b1, last: 1'b0};
          res.count = 2'd2;
        end else begin
          res.ent[0] = '{data: UTF8_LEAD3 | {4'b0000, hv_upd[15:12]}, valid: 1'b1,
                         last: 1'b0};
          res.ent[1] = '{data: UTF8_CONT | (hv_upd[13:6] & UTF8_MASK), valid: 1'b1,
                         last: 1'b0};
          res.ent[2] = '{data: UTF8_CONT | (hv_upd[7:0] & UTF8_MASK), valid: 1'b1, last: 1'b0};
          res.count = 2'd3;
        end
        mode_next = MODE_NORMAL;
        hex_value_next = '0;
        hex_stopped_next = 1'b0;
      end
      default: begin
        // normal text
        mode_next = MODE_NORMAL;
        if (in_byte == CH_QUOTE) ended = 1'b1;
        else if (in_byte == CH_BSLASH) mode_next = MODE_ESC;
        else begin
          res.ent[0] = '{data: in_byte, valid: 1'b1, last: 1'b0};
          res.count = 2'd1;
        end
      end
    endcase

    if (ended || in_last) begin
      unique case (res.count)
        2'd1:    res.ent[0].last = 1'b1;
        2'd2:    res.ent[1].last = 1'b1;
        2'd3:    res.ent[2].last = 1'b1;
        default: begin
          // nothing pending (quote, or an escape cut short): bare end marker
          res.ent[0] = '{data: 8'h00, valid: 1'b0, last: 1'b1};
          res.count = 2'd1;
        end
      endcase
      mode_next = MODE_NORMAL;
      hex_value_next = '0;
      hex_stopped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      hex_value <= '0;
      hex_stopped <= 1'b0;
    end else if (step) begin
      mode <= mode_next;
      hex_value <= hex_value_next;
      hex_stopped <= hex_stopped_next;
    end
  end

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    step && (in_last || (mode == MODE_NORMAL && in_byte == CH_QUOTE))
    |=> mode == MODE_NORMAL && hex_value == '0 && !hex_stopped)
    else $error("decode state not cleared after string end");

  a_hex_fresh: assert property (@(posedge clk) disable iff (rst)
    step && mode == MODE_ESC && in_byte == CH_U && !in_last
    |=> mode == MODE_HEX1 && hex_value == '0 && !hex_stopped)
    else $error("unicode escape did not start clean");

endmodule

@@ hw/rtl/json_string_unescape_unit.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape_unit
// JSON string body unescaper: decodes escapes and emits UTF-8 bytes.
// ----------------------------------------------------------------------------
//  channel | direction | tdata          | tlast      | tuser
//  s_      | in        | in_byte[7:0]   | in_last    | -
//  m_      | out       | out_byte[7:0]  | string_end | byte_valid
//
//  One body byte per cycle is taken while each byte yields at most one
//  result and m_ does not stall; a byte that yields more results (UTF-8 of a
//  \u escape) holds the output until all of them have left, which sets the rate.
//  Path: input register, then decode into the result buffer.
//  rst (synchronous) empties both registers and returns to normal text.
//  A stall on m_ backs up through the result buffer to s_tready.
// ----------------------------------------------------------------------------
module json_string_unescape_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // in_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // [0] byte_valid
  output logic       m_tlast    // string_end
);
  import jsu_pkg::*;

  // input register
  logic       ir_valid;
  logic [7:0] ir_byte;
  logic       ir_last;

  // result buffer: up to three results of one byte, head at entry 0
  entry_t [MaxResults-1:0] q;
  logic [1:0]              cnt;

  result_set_t res;
  logic        take, load_ok, step;

  assign m_tvalid = (cnt != 2'd0);
  assign take = m_tvalid && m_tready;
  // buffer can take a new set when empty or its last entry leaves now
  assign load_ok = (cnt == 2'd0) || (cnt == 2'd1 && m_tready);
  assign step = ir_valid && load_ok;
  assign s_tready = !ir_valid || load_ok;

  jsu_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (ir_byte),
    .in_last (ir_last),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (s_tready) begin
      ir_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      ir_byte <= s_tdata;
      ir_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (step) begin
      cnt <= res.count;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      q <= res.ent;
    end else if (take) begin
      q[0] <= q[1];
      q[1] <= q[2];
    end
  end

  assign m_tdata = q[0].data;
  assign m_tuser = q[0].valid;
  assign m_tlast = q[0].last;

  a_load_safe: assert property (@(posedge clk) disable iff (rst)
    step |-> cnt == 2'd0 || (cnt == 2'd1 && take))
    else $error("result set loaded over pending results");

  a_end_is_tail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> cnt == 2'd1)
    else $error("string end not on final buffered result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("buffers not empty after reset");

endmodule
